// ----- src/lpc_pkg.sv -----
// lpc_pkg: shared constants of the lru page cache policy block
// no dependencies; compiled first
`timescale 1ns / 1ps

package lpc_pkg;

	// width of page number fields on the request and response channels
	localparam int PAGE_NUM_W = 52;

endpackage

// ----- src/lpc_if.sv -----
// lpc_req_if, lpc_rsp_if: valid/ready channels of the lru page cache policy block
// depends on lpc_pkg for the page number width
`timescale 1ns / 1ps

interface lpc_req_if;
	import lpc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PAGE_NUM_W-1:0] page_number;
	logic                  fill_ok;

	modport source (output valid, page_number, fill_ok, input ready);
	modport sink   (input valid, page_number, fill_ok, output ready);
endinterface

interface lpc_rsp_if #(
	parameter int SLOT_W = 5
);
	import lpc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  ok;
	logic                  hit;
	logic [SLOT_W-1:0]     slot;
	logic                  evicted_valid;
	logic [PAGE_NUM_W-1:0] evicted_page;

	modport source (output valid, ok, hit, slot, evicted_valid, evicted_page, input ready);
	modport sink   (input valid, ok, hit, slot, evicted_valid, evicted_page, output ready);
endinterface

// ----- src/lpc_ram.sv -----
// lpc_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module lpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/lru_page_cache_policy_top.sv -----
// lru_page_cache_policy_top: fully associative lru page cache policy with a free slot fifo
// depends on lpc_pkg, lpc_req_if, lpc_rsp_if and lpc_ram
`timescale 1ns / 1ps

// One request at a time. After a request transfer the block sweeps all CACHE_SLOTS slots
// through the tag and rank rams, one slot per cycle, to find a hit, count the valid slots
// and pick the least recent one. A miss served from the free fifo is answered after this
// sweep; a hit or an eviction needs a second sweep of the rank ram to close the recency
// gap. The rank ram port is read once per slot in each sweep. req.ready is high only
// between requests; a finished response waits in the output register and does not block
// the next request. There is no clearing pass after reset.

module lru_page_cache_policy_top #(
	parameter int CACHE_SLOTS = 32,
	parameter int PAGE_BITS   = 52
) (
	input  logic      clk,
	input  logic      arst_n,
	lpc_req_if.sink   req,
	lpc_rsp_if.source rsp
);
	import lpc_pkg::*;

	localparam int SLOT_W = $clog2(CACHE_SLOTS);
	localparam int RANK_W = SLOT_W;
	localparam int CNT_W  = $clog2(CACHE_SLOTS + 1);
	localparam int TAG_W  = (PAGE_BITS < PAGE_NUM_W) ? PAGE_BITS : PAGE_NUM_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_SLOTS - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CACHE_SLOTS);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_SCAN     = 7'b0000010,
		ST_LAST     = 7'b0000100,
		ST_DECIDE   = 7'b0001000,
		ST_UPD      = 7'b0010000,
		ST_UPD_LAST = 7'b0100000,
		ST_RESP     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// request and sweep control
	logic [TAG_W-1:0]       page_q;
	logic                   fill_q;
	logic [CACHE_SLOTS-1:0] valid_q;
	logic [SLOT_W-1:0]      cnt_q;
	logic [SLOT_W-1:0]      idx_s1;
	logic                   rd_s1;

	// scan results
	logic [CNT_W-1:0]  n_q;
	logic              found_q;
	logic [SLOT_W-1:0] hit_slot_q;
	logic [RANK_W-1:0] hit_rank_q;
	logic              any_q;
	logic [SLOT_W-1:0] lru_q;
	logic [RANK_W-1:0] lru_rank_q;
	logic [TAG_W-1:0]  lru_tag_q;

	// rank update sweep
	logic [SLOT_W-1:0] tgt_q;
	logic [RANK_W-1:0] gap_rank_q;
	logic [RANK_W-1:0] new_rank_q;

	// result waiting for the output register
	logic                  res_ok_q;
	logic                  res_hit_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic                  res_ev_q;
	logic [PAGE_NUM_W-1:0] res_evpage_q;

	// output register
	logic                  rsp_vld_q;
	logic                  rsp_ok_q;
	logic                  rsp_hit_q;
	logic [SLOT_W-1:0]     rsp_slot_q;
	logic                  rsp_ev_q;
	logic [PAGE_NUM_W-1:0] rsp_evpage_q;

	// free fifo pointers; wr_fill_q counts entries written since reset
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [CNT_W-1:0]  fcount_q;
	logic [CNT_W-1:0]  wr_fill_q;

	// ram ports
	logic [TAG_W-1:0]  tag_rd;
	logic              tag_we;
	logic [RANK_W-1:0] rank_rd;
	logic              rank_we;
	logic [SLOT_W-1:0] rank_waddr;
	logic [RANK_W-1:0] rank_wdata;
	logic [SLOT_W-1:0] fifo_rd;
	logic              fifo_we;

	// decision terms
	logic              req_xfer;
	logic              scan_data;
	logic              upd_data;
	logic              out_free;
	logic [SLOT_W-1:0] fifo_slot;
	logic              pop;
	logic              have_free;
	logic              evict;
	logic              placed;
	logic              push;
	logic [CNT_W-1:0]  fcount_pop;
	logic [SLOT_W-1:0] miss_slot;
	logic              upd_wr;
	logic [RANK_W-1:0] upd_val;

	assign req_xfer  = req.valid && req.ready;
	assign scan_data = rd_s1 && (state_q == ST_SCAN || state_q == ST_LAST);
	assign upd_data  = rd_s1 && (state_q == ST_UPD || state_q == ST_UPD_LAST);
	assign out_free  = !rsp_vld_q || rsp.ready;

	// fifo head entry; a position never written stands for the slot of its own index
	assign fifo_slot = ({{(CNT_W - SLOT_W){1'b0}}, head_q} < wr_fill_q) ? fifo_rd : head_q;

	// miss handling decisions, used in the decide state
	always_comb begin
		pop        = !found_q && (fcount_q != '0);
		have_free  = pop && !valid_q[fifo_slot];
		evict      = !found_q && !have_free && any_q;
		placed     = have_free || evict;
		fcount_pop = pop ? fcount_q - CNT_W'(1) : fcount_q;
		push       = placed && !fill_q && (fcount_pop < FULL_CNT);
		miss_slot  = have_free ? fifo_slot : lru_q;
	end

	// rank update of one swept slot
	always_comb begin
		upd_wr  = 1'b0;
		upd_val = new_rank_q;
		if (idx_s1 == tgt_q) begin
			upd_wr = 1'b1;
		end else if (valid_q[idx_s1] && (rank_rd > gap_rank_q)) begin
			upd_wr  = 1'b1;
			upd_val = rank_rd - RANK_W'(1);
		end
	end

	// rank ram write select
	always_comb begin
		rank_we    = 1'b0;
		rank_waddr = idx_s1;
		rank_wdata = upd_val;
		if (state_q == ST_DECIDE) begin
			rank_we    = have_free;
			rank_waddr = fifo_slot;
			rank_wdata = RANK_W'(n_q);
		end else if (upd_data) begin
			rank_we = upd_wr;
		end
	end

	assign tag_we  = (state_q == ST_DECIDE) && placed;
	assign fifo_we = (state_q == ST_DECIDE) && push;

	lpc_ram #(.WIDTH(TAG_W), .DEPTH(CACHE_SLOTS)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (miss_slot),
		.wdata (page_q),
		.raddr (cnt_q),
		.rdata (tag_rd)
	);

	lpc_ram #(.WIDTH(RANK_W), .DEPTH(CACHE_SLOTS)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rank_waddr),
		.wdata (rank_wdata),
		.raddr (cnt_q),
		.rdata (rank_rd)
	);

	lpc_ram #(.WIDTH(SLOT_W), .DEPTH(CACHE_SLOTS)) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (tail_q),
		.wdata (miss_slot),
		.raddr (head_q),
		.rdata (fifo_rd)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_xfer) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_q == LAST_SLOT) state_d = ST_LAST;
			end
			ST_LAST: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = (found_q || evict) ? ST_UPD : ST_RESP;
			end
			ST_UPD: begin
				if (cnt_q == LAST_SLOT) state_d = ST_UPD_LAST;
			end
			ST_UPD_LAST: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sweep counter and read pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_SCAN) || (state_q == ST_UPD);
			if (state_q == ST_SCAN || state_q == ST_UPD) begin
				cnt_q <= (cnt_q == LAST_SLOT) ? '0 : cnt_q + SLOT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
	end

	// request capture and scan accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			any_q   <= 1'b0;
			n_q     <= '0;
		end else if (req_xfer) begin
			found_q <= 1'b0;
			any_q   <= 1'b0;
			n_q     <= '0;
		end else if (scan_data && valid_q[idx_s1]) begin
			n_q <= n_q + CNT_W'(1);
			if (!found_q && (tag_rd == page_q)) begin
				found_q <= 1'b1;
			end
			if (!any_q || (rank_rd < lru_rank_q)) begin
				any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			page_q <= req.page_number[TAG_W-1:0];
			fill_q <= req.fill_ok;
		end
		if (scan_data && valid_q[idx_s1]) begin
			if (!found_q && (tag_rd == page_q)) begin
				hit_slot_q <= idx_s1;
				hit_rank_q <= rank_rd;
			end
			if (!any_q || (rank_rd < lru_rank_q)) begin
				lru_q      <= idx_s1;
				lru_rank_q <= rank_rd;
				lru_tag_q  <= tag_rd;
			end
		end
	end

	// slot valid bits and free fifo pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			fcount_q  <= FULL_CNT;
			wr_fill_q <= '0;
		end else if (state_q == ST_DECIDE && !found_q) begin
			if (placed) begin
				valid_q[miss_slot] <= fill_q;
			end
			if (pop) begin
				head_q <= (head_q == LAST_SLOT) ? '0 : head_q + SLOT_W'(1);
			end
			if (push) begin
				tail_q <= (tail_q == LAST_SLOT) ? '0 : tail_q + SLOT_W'(1);
				if (wr_fill_q != FULL_CNT) begin
					wr_fill_q <= wr_fill_q + CNT_W'(1);
				end
			end
			fcount_q <= push ? fcount_pop + CNT_W'(1) : fcount_pop;
		end
	end

	// result and rank sweep targets
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE) begin
			if (found_q) begin
				tgt_q        <= hit_slot_q;
				gap_rank_q   <= hit_rank_q;
				new_rank_q   <= RANK_W'(n_q - CNT_W'(1));
				res_ok_q     <= 1'b1;
				res_hit_q    <= 1'b1;
				res_slot_q   <= hit_slot_q;
				res_ev_q     <= 1'b0;
				res_evpage_q <= '0;
			end else begin
				tgt_q        <= lru_q;
				gap_rank_q   <= lru_rank_q;
				new_rank_q   <= RANK_W'(n_q - CNT_W'(1));
				res_ok_q     <= placed && fill_q;
				res_hit_q    <= 1'b0;
				res_slot_q   <= (placed && fill_q) ? miss_slot : '0;
				res_ev_q     <= evict;
				res_evpage_q <= evict ? PAGE_NUM_W'(lru_tag_q) : '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			rsp_ok_q     <= res_ok_q;
			rsp_hit_q    <= res_hit_q;
			rsp_slot_q   <= res_slot_q;
			rsp_ev_q     <= res_ev_q;
			rsp_evpage_q <= res_evpage_q;
		end
	end

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = rsp_vld_q;
	assign rsp.ok            = rsp_ok_q;
	assign rsp.hit           = rsp_hit_q;
	assign rsp.slot          = rsp_slot_q;
	assign rsp.evicted_valid = rsp_ev_q;
	assign rsp.evicted_page  = rsp_evpage_q;

endmodule

// ----- src/lpc_checker.sv -----
// lpc_checker: port-level assertions for lru_page_cache_policy_top, with its bind
// depends on lpc_pkg; bound into lru_page_cache_policy_top
`timescale 1ns / 1ps

module lpc_checker #(
	parameter int SLOT_W = 5
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic                           rsp_ok,
	input logic                           rsp_hit,
	input logic [SLOT_W-1:0]              rsp_slot,
	input logic                           rsp_evicted_valid,
	input logic [lpc_pkg::PAGE_NUM_W-1:0] rsp_evicted_page
);
	import lpc_pkg::*;

	logic [1:0] pending_q;
	logic       req_xfer;
	logic       rsp_xfer;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	// requests taken whose response has not yet been transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_xfer && !rsp_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (rsp_xfer && !req_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// one request in the sequencer at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> !req_ready)
		else $error("request taken while the previous one is still in work");

	// no response without a request behind it
	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response without an outstanding request");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot)
			&& $stable(rsp_evicted_page) && $stable(rsp_ok))
		else $error("stalled response changed");

	// a hit returns a slot and never evicts
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_hit |-> rsp_ok && !rsp_evicted_valid
			&& rsp_evicted_page == '0)
		else $error("hit response with eviction or failure");

	// a failed fill reports slot zero
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_slot == '0 && !rsp_hit)
		else $error("failed response with a slot or hit");

endmodule

bind lru_page_cache_policy_top lpc_checker #(.SLOT_W(SLOT_W)) u_lpc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_ok            (rsp.ok),
	.rsp_hit           (rsp.hit),
	.rsp_slot          (rsp.slot),
	.rsp_evicted_valid (rsp.evicted_valid),
	.rsp_evicted_page  (rsp.evicted_page)
);
